/* rtl/stepper_move_controller_macros.svh */
// ----------------------------------------------------------------------------
// Stepper move controller assertion macros
// Shared concurrent assertion forms, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MOVE_CONTROLLER_MACROS_SVH
`define STEPPER_MOVE_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STPMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/stpmc_pkg.sv */
// ----------------------------------------------------------------------------
// stpmc_pkg
// Widths, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpmc_pkg;

	localparam int unsigned PERIOD_BITS_DEF = 16;
	localparam int unsigned TICK_RATE_W     = 24;
	localparam int unsigned POS_W           = 32;
	localparam int unsigned SPEED_W         = 24;
	localparam int unsigned TIME_W          = 24;
	localparam int unsigned FRAME_W         = 8;
	localparam int unsigned CMD_W           = 3;
	localparam int unsigned MULT_W          = 10;
	// mag * 1000 stays below 2^41
	localparam int unsigned DIV_W           = 42;
	localparam int unsigned IN_W            = 88;
	localparam int unsigned OUT_W           = 72;

	localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 24'd9000000;
	localparam logic [MULT_W-1:0]      MS_PER_SECOND   = 10'd1000;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_JOG    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ARRIVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FRAME  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ZERO   = 3'd4;

	typedef enum logic [1:0] {
		SPD_SRC_SPEED,
		SPD_SRC_PROD,
		SPD_SRC_QUO
	} spd_src_t;

	typedef enum logic {
		DIV_ARRIVE,
		DIV_PERIOD
	} div_op_t;

	typedef struct packed {
		logic     load_in;
		logic     exec;
		logic     mul;
		logic     ld_spd;
		spd_src_t spd_src;
		logic     div_start;
		div_op_t  div_op;
		logic     start_move;
		logic     load_out;
		logic     err;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             mag_zero;
		logic             time_zero;
		logic             spd_zero;
		logic             div_done;
	} dp_stat_t;

endpackage

/* rtl/stepper_move_controller.sv */
// ----------------------------------------------------------------------------
// stepper_move_controller
// Step/direction generator: base ticks advance the move, commands set it up.
//
// Channel  Dir  Handshake          Payload
// cfg      in   cfg_we             cfg_wdata: tick_rate
// s        in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: goal..fps
// m        out  m_tvalid/m_tready  m_tdata: step_pulse..speed_error
//
// Tick, zero and unused codes: accept, execute and result steps per item.
// Jog: period divide; frame: multiply, period divide; arrive: multiply, speed
// divide, period divide, on the shared one-bit-per-cycle divider (DIV_W = 42).
// Next item is taken while the result register still waits on m_tready;
// a stalled result holds the sequencer in its final step.
// Reset: position 0, direction forward, no move, tick_rate 9000000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_move_controller #(
	parameter int unsigned PERIOD_BITS = stpmc_pkg::PERIOD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stpmc_pkg::TICK_RATE_W-1:0] cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] goal, [55:32] speed, [79:56] time_ms, [87:80] fps
	input  logic [stpmc_pkg::IN_W-1:0]        s_tdata,
	// [2:0] cmd
	input  logic [stpmc_pkg::CMD_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] step_pulse, [1] dir, [33:2] position, [34] moving,
	// [66:35] remaining, [67] speed_error, [71:68] zero
	output logic [stpmc_pkg::OUT_W-1:0]       m_tdata
);

	stpmc_pkg::dp_cmd_t  dp_cmd;
	stpmc_pkg::dp_stat_t dp_stat;

	stpmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	stpmc_datapath #(
		.PERIOD_BITS (PERIOD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_cmd    (s_tuser),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.out_data  (m_tdata)
	);

endmodule

/* rtl/stpmc_div.sv */
// ----------------------------------------------------------------------------
// stpmc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpmc_div #(
	parameter int unsigned W = stpmc_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int unsigned CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    shifted;
	logic [W:0]    trial;
	logic          ge;

	assign shifted = {rem_q, quo_q[W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= ge ? trial[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/stpmc_datapath.sv */
// ----------------------------------------------------------------------------
// stpmc_datapath
// Position, step count and period state, speed/period arithmetic, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpmc_datapath #(
	parameter int unsigned PERIOD_BITS = stpmc_pkg::PERIOD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stpmc_pkg::TICK_RATE_W-1:0]   cfg_wdata,
	input  logic [stpmc_pkg::IN_W-1:0]          in_data,
	input  logic [stpmc_pkg::CMD_W-1:0]         in_cmd,
	input  stpmc_pkg::dp_cmd_t                  cmd,
	output stpmc_pkg::dp_stat_t                 stat,
	output logic [stpmc_pkg::OUT_W-1:0]         out_data
);

	localparam int unsigned DW = stpmc_pkg::DIV_W;
	localparam int unsigned PW = stpmc_pkg::POS_W;
	localparam logic [DW-1:0] PMAX = {{(DW - PERIOD_BITS){1'b0}}, {PERIOD_BITS{1'b1}}};
	localparam int unsigned PAD_W = stpmc_pkg::OUT_W - (2 * PW + 4);

	// latched input item
	logic [stpmc_pkg::CMD_W-1:0]       cmd_q;
	logic [PW-1:0]                     goal_q;
	logic [stpmc_pkg::SPEED_W-1:0]     speed_q;
	logic [stpmc_pkg::TIME_W-1:0]      time_q;
	logic [stpmc_pkg::FRAME_W-1:0]     frame_q;

	// motion state
	logic [stpmc_pkg::TICK_RATE_W-1:0] tick_rate_q;
	logic [PW-1:0]                     pos_q;
	logic [PW-1:0]                     steps_q;
	logic                              dir_q;
	logic [PERIOD_BITS-1:0]            reload_q;
	logic [PERIOD_BITS-1:0]            count_q;

	// move set-up
	logic [PW-1:0]                     mag_q;
	logic [DW-1:0]                     prod_q;
	logic [DW-1:0]                     spd_q;
	logic                              pulse_q;
	logic [stpmc_pkg::OUT_W-1:0]       out_q;

	logic [PW-1:0]                     delta;
	logic [PW-1:0]                     mag;
	logic [stpmc_pkg::MULT_W-1:0]      mult;
	logic [DW-1:0]                     div_dividend;
	logic [DW-1:0]                     div_divisor;
	logic                              div_done;
	logic [DW-1:0]                     quo;
	logic [DW-1:0]                     quo_m1;
	logic [PERIOD_BITS-1:0]            period_nxt;

	assign delta = goal_q - pos_q;
	assign mag   = delta[PW-1] ? (PW'(0) - delta) : delta;
	assign mult  = (cmd_q == stpmc_pkg::CMD_ARRIVE) ? stpmc_pkg::MS_PER_SECOND
	                                                : {2'b00, frame_q};

	assign div_dividend = (cmd.div_op == stpmc_pkg::DIV_ARRIVE) ? prod_q : DW'(tick_rate_q);
	assign div_divisor  = (cmd.div_op == stpmc_pkg::DIV_ARRIVE) ? DW'(time_q) : spd_q;

	stpmc_div #(
		.W (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// period = tick_rate / speed - 1, clamped to [0, 2^PERIOD_BITS - 1]
	assign quo_m1 = quo - 1'b1;
	always_comb begin
		if (quo == '0)
			period_nxt = '0;
		else if (quo_m1 > PMAX)
			period_nxt = PMAX[PERIOD_BITS-1:0];
		else
			period_nxt = quo_m1[PERIOD_BITS-1:0];
	end

	assign stat.cmd       = cmd_q;
	assign stat.mag_zero  = (mag == '0);
	assign stat.time_zero = (time_q == '0);
	assign stat.spd_zero  = (spd_q == '0);
	assign stat.div_done  = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= stpmc_pkg::TICK_RATE_RESET;
			pos_q       <= '0;
			steps_q     <= '0;
			dir_q       <= 1'b1;
			reload_q    <= '0;
			count_q     <= '0;
		end else begin
			if (cfg_we)
				tick_rate_q <= cfg_wdata;
			if (cmd.exec) begin
				case (cmd_q)
					stpmc_pkg::CMD_TICK: begin
						if (steps_q != '0) begin
							if (count_q >= reload_q) begin
								count_q <= '0;
								pos_q   <= dir_q ? (pos_q + 1'b1) : (pos_q - 1'b1);
								steps_q <= steps_q - 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
					end
					stpmc_pkg::CMD_JOG, stpmc_pkg::CMD_ARRIVE, stpmc_pkg::CMD_FRAME: begin
						steps_q <= '0;
						count_q <= '0;
						dir_q   <= ~delta[PW-1];
					end
					stpmc_pkg::CMD_ZERO: begin
						steps_q <= '0;
						count_q <= '0;
						pos_q   <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.start_move) begin
				reload_q <= period_nxt;
				steps_q  <= mag_q;
				count_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= in_cmd;
			goal_q  <= in_data[31:0];
			speed_q <= in_data[55:32];
			time_q  <= in_data[79:56];
			frame_q <= in_data[87:80];
		end
		if (cmd.exec) begin
			mag_q   <= mag;
			pulse_q <= (cmd_q == stpmc_pkg::CMD_TICK) && (steps_q != '0)
			           && (count_q >= reload_q);
		end
		if (cmd.mul)
			prod_q <= DW'(mag_q) * DW'(mult);
		if (cmd.ld_spd) begin
			case (cmd.spd_src)
				stpmc_pkg::SPD_SRC_SPEED: spd_q <= DW'(speed_q);
				stpmc_pkg::SPD_SRC_PROD:  spd_q <= prod_q;
				default:                  spd_q <= quo;
			endcase
		end
		if (cmd.load_out)
			out_q <= {{PAD_W{1'b0}}, cmd.err, steps_q, (steps_q != '0), pos_q, dir_q, pulse_q};
	end

	assign out_data = out_q;

endmodule

/* rtl/stpmc_ctrl.sv */
// ----------------------------------------------------------------------------
// stpmc_ctrl
// Sequencer: input handshake, move set-up steps, result register valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  stpmc_pkg::dp_stat_t stat,
	output stpmc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_AFTER_MUL,
		ST_WAIT_ARR,
		ST_CHECK,
		ST_WAIT_PER,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   err_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.spd_src = stpmc_pkg::SPD_SRC_SPEED;
		cmd.div_op  = stpmc_pkg::DIV_ARRIVE;
		cmd.err     = err_q;
		unique case (state_q)
			ST_IDLE: cmd.load_in = s_tvalid;
			ST_EXEC: begin
				cmd.exec   = 1'b1;
				cmd.ld_spd = (stat.cmd == stpmc_pkg::CMD_JOG) && !stat.mag_zero;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_AFTER_MUL: begin
				if (stat.cmd == stpmc_pkg::CMD_ARRIVE) begin
					cmd.div_start = 1'b1;
				end else begin
					cmd.ld_spd  = 1'b1;
					cmd.spd_src = stpmc_pkg::SPD_SRC_PROD;
				end
			end
			ST_WAIT_ARR: begin
				cmd.ld_spd  = stat.div_done;
				cmd.spd_src = stpmc_pkg::SPD_SRC_QUO;
			end
			ST_CHECK: begin
				cmd.div_start = !stat.spd_zero;
				cmd.div_op    = stpmc_pkg::DIV_PERIOD;
			end
			ST_WAIT_PER: cmd.start_move = stat.div_done;
			ST_FIN:      cmd.load_out   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					err_q <= 1'b0;
					unique case (stat.cmd)
						stpmc_pkg::CMD_JOG: state_q <= stat.mag_zero ? ST_FIN : ST_CHECK;
						stpmc_pkg::CMD_FRAME: state_q <= stat.mag_zero ? ST_FIN : ST_MUL;
						stpmc_pkg::CMD_ARRIVE: begin
							if (stat.mag_zero) begin
								state_q <= ST_FIN;
							end else if (stat.time_zero) begin
								err_q   <= 1'b1;
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_MUL;
							end
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_MUL: state_q <= ST_AFTER_MUL;
				ST_AFTER_MUL: begin
					state_q <= (stat.cmd == stpmc_pkg::CMD_ARRIVE) ? ST_WAIT_ARR : ST_CHECK;
				end
				ST_WAIT_ARR: begin
					if (stat.div_done)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (stat.spd_zero) begin
						err_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_WAIT_PER;
					end
				end
				ST_WAIT_PER: begin
					if (stat.div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/stpmc_checker.sv */
// ----------------------------------------------------------------------------
// stpmc_checker
// Port-level checks on the stepper move controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_move_controller_macros.svh"

module stpmc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [stpmc_pkg::OUT_W-1:0] m_tdata
);

	logic in_xfer;
	logic out_stall;
	logic out_err;
	logic err_idle;

	assign in_xfer   = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;
	assign out_err   = m_tvalid && m_tdata[67];
	assign err_idle  = !m_tdata[34] && !m_tdata[0] && (m_tdata[66:35] == 32'd0);

	// stalled result keeps valid and payload
	`STPMC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")

	// one item at a time: a transfer in closes the input side for the next cycle
	`STPMC_ASSERT_NEXT(a_one_item, in_xfer, !s_tready, "input taken twice in a row")

	// a rejected move leaves nothing to step and emits no pulse
	`STPMC_ASSERT_NOW(a_err_idle, out_err, err_idle, "speed error with motion")

endmodule

bind stepper_move_controller stpmc_checker u_stpmc_checker (.*);

/* bench/stepper_move_controller_test.sv */
// ----------------------------------------------------------------------------
// stepper_move_controller_test
// Self-checking bench. Stream transfers are driven from a queue of commands and
// ticks. Each accepted item is run through a predictor of the move controller.
// Each result is checked field by field against the oldest predicted status.
// tick_rate is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_move_controller_test;

	localparam logic [stpmc_pkg::CMD_W-1:0] CMD_LAST = 3'd7;
	localparam logic [63:0] PERIOD_MAX = (64'd1 << stpmc_pkg::PERIOD_BITS_DEF) - 64'd1;

	typedef struct packed {
		logic [stpmc_pkg::CMD_W-1:0]   cmd;
		logic [stpmc_pkg::POS_W-1:0]   goal;
		logic [stpmc_pkg::SPEED_W-1:0] speed;
		logic [stpmc_pkg::TIME_W-1:0]  time_ms;
		logic [stpmc_pkg::FRAME_W-1:0] fps;
	} move_item_t;

	typedef struct packed {
		logic                        step_pulse;
		logic                        dir;
		logic [stpmc_pkg::POS_W-1:0] position;
		logic                        moving;
		logic [31:0]                 remaining;
		logic                        speed_error;
	} motion_status_t;

	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              cfg_we     = 1'b0;
	logic [stpmc_pkg::TICK_RATE_W-1:0] cfg_wdata  = '0;
	logic                              s_tvalid   = 1'b0;
	logic                              s_tready;
	logic [stpmc_pkg::IN_W-1:0]        s_tdata    = '0;
	logic [stpmc_pkg::CMD_W-1:0]       s_tuser    = '0;
	logic                              m_tvalid;
	logic                              m_tready   = 1'b0;
	logic [stpmc_pkg::OUT_W-1:0]       m_tdata;

	move_item_t     command_q[$];
	motion_status_t status_q[$];
	move_item_t     item_on_bus;
	int             mismatches = 0;

	// model of the controller state
	logic [stpmc_pkg::TICK_RATE_W-1:0] rate_m     = stpmc_pkg::TICK_RATE_RESET;
	logic [stpmc_pkg::POS_W-1:0]       position_m = '0;
	logic [31:0]                       steps_m    = '0;
	logic                              dir_m      = 1'b1;
	logic [63:0]                       reload_m   = '0;
	logic [63:0]                       count_m    = '0;

	stepper_move_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic motion_status_t track_motion(input move_item_t it);
		motion_status_t st;
		logic [31:0]    delta;
		logic [31:0]    mag;
		logic [63:0]    rate;
		logic [63:0]    quo;
		st = '0;
		case (it.cmd)
			stpmc_pkg::CMD_TICK: begin
				if (steps_m != 0) begin
					if (count_m >= reload_m) begin
						count_m = 0;
						st.step_pulse = 1'b1;
						position_m = position_m + (dir_m ? 32'd1 : 32'hFFFF_FFFF);
						steps_m = steps_m - 1;
					end else
						count_m = count_m + 1;
				end
			end
			stpmc_pkg::CMD_JOG, stpmc_pkg::CMD_ARRIVE, stpmc_pkg::CMD_FRAME: begin
				steps_m = 0;
				count_m = 0;
				delta = it.goal - position_m;
				dir_m = ~delta[31];
				mag = delta[31] ? (32'd0 - delta) : delta;
				if (mag != 0) begin
					if (it.cmd == stpmc_pkg::CMD_JOG)
						rate = 64'(it.speed);
					else if (it.cmd == stpmc_pkg::CMD_ARRIVE)
						rate = (it.time_ms == 0) ? 64'd0 :
							(64'(mag) * 64'(stpmc_pkg::MS_PER_SECOND)) / 64'(it.time_ms);
					else
						rate = 64'(mag) * 64'(it.fps);
					if (rate == 0)
						st.speed_error = 1'b1;
					else begin
						quo = 64'(rate_m) / rate;
						if (quo == 0)
							reload_m = 0;
						else if (quo - 1 > PERIOD_MAX)
							reload_m = PERIOD_MAX;
						else
							reload_m = quo - 1;
						steps_m = mag;
					end
				end
			end
			stpmc_pkg::CMD_ZERO: begin
				steps_m = 0;
				count_m = 0;
				position_m = 0;
			end
			default: ;
		endcase
		st.dir = dir_m;
		st.position = position_m;
		st.moving = (steps_m != 0);
		st.remaining = steps_m;
		return st;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// driver: one wait draw per item, with calm stretches of back-to-back transfers
	int drv_gap  = 0;
	bit drv_calm = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				status_q.push_back(track_motion(item_on_bus));
			if (drv_gap > 0) begin
				drv_gap--;
				s_tvalid <= 1'b0;
			end else if (command_q.size() != 0) begin
				item_on_bus = command_q.pop_front();
				s_tuser <= item_on_bus.cmd;
				s_tdata <= {item_on_bus.fps, item_on_bus.time_ms,
					item_on_bus.speed, item_on_bus.goal};
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					drv_calm = ~drv_calm;
				drv_gap = drv_calm ? 0 : $urandom_range(0, 16);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// monitor: checks each result transfer, stalls between some transfers
	int mon_hold = 0;
	bit mon_calm = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		motion_status_t want;
		motion_status_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.step_pulse  = m_tdata[0];
				got.dir         = m_tdata[1];
				got.position    = m_tdata[33:2];
				got.moving      = m_tdata[34];
				got.remaining   = m_tdata[66:35];
				got.speed_error = m_tdata[67];
				if (status_q.size() == 0)
					report_mismatch("result transfer with nothing pending");
				else begin
					want = status_q.pop_front();
					if (got.step_pulse !== want.step_pulse)
						report_mismatch($sformatf("step_pulse %b, want %b",
							got.step_pulse, want.step_pulse));
					if (got.dir !== want.dir)
						report_mismatch($sformatf("dir %b, want %b", got.dir, want.dir));
					if (got.position !== want.position)
						report_mismatch($sformatf("position %h, want %h",
							got.position, want.position));
					if (got.moving !== want.moving)
						report_mismatch($sformatf("moving %b, want %b",
							got.moving, want.moving));
					if (got.remaining !== want.remaining)
						report_mismatch($sformatf("remaining %h, want %h",
							got.remaining, want.remaining));
					if (got.speed_error !== want.speed_error)
						report_mismatch($sformatf("speed_error %b, want %b",
							got.speed_error, want.speed_error));
				end
				if ($urandom_range(0, 31) == 0)
					mon_calm = ~mon_calm;
				mon_hold = mon_calm ? 0 : $urandom_range(0, 16);
			end else if (mon_hold > 0)
				mon_hold--;
			m_tready <= (mon_hold == 0);
		end
	end

	task automatic queue_item(input logic [stpmc_pkg::CMD_W-1:0] cmd,
			input logic [stpmc_pkg::POS_W-1:0] goal,
			input logic [stpmc_pkg::SPEED_W-1:0] speed,
			input logic [stpmc_pkg::TIME_W-1:0] time_ms,
			input logic [stpmc_pkg::FRAME_W-1:0] fps);
		move_item_t it;
		it.cmd = cmd;
		it.goal = goal;
		it.speed = speed;
		it.time_ms = time_ms;
		it.fps = fps;
		command_q.push_back(it);
	endtask

	// ticks carry random junk in the unused fields
	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_item(stpmc_pkg::CMD_TICK, $urandom, 24'($urandom), 24'($urandom),
				8'($urandom));
	endtask

	task automatic wait_idle();
		while (command_q.size() != 0 || status_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tick_rate(input logic [stpmc_pkg::TICK_RATE_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_m = value;
	endtask

	// mostly a move toward a nearby goal followed by a burst of ticks
	task automatic queue_random_moves(input int n);
		int                            done;
		int                            burst;
		logic [stpmc_pkg::CMD_W-1:0]   cmd;
		logic [stpmc_pkg::POS_W-1:0]   goal;
		logic [stpmc_pkg::SPEED_W-1:0] speed;
		logic [stpmc_pkg::TIME_W-1:0]  time_ms;
		done = 0;
		while (done < n) begin
			case ($urandom_range(0, 9))
				0: begin
					cmd = 3'($urandom_range(0, CMD_LAST));
					queue_item(cmd, $urandom, 24'($urandom), 24'($urandom), 8'($urandom));
					if (cmd <= stpmc_pkg::CMD_ZERO)
						done++;
				end
				1: begin
					queue_item(stpmc_pkg::CMD_ZERO, $urandom, 24'($urandom), 24'($urandom),
						8'($urandom));
					done++;
				end
				default: begin
					cmd = 3'($urandom_range(stpmc_pkg::CMD_JOG, stpmc_pkg::CMD_FRAME));
					goal = ($urandom_range(0, 7) == 0) ? 32'($urandom) :
						32'($urandom_range(0, 80)) - 32'd40;
					case ($urandom_range(0, 3))
						0: speed = 24'($urandom_range(0, 3));
						1: speed = 24'($urandom);
						default: speed = (rate_m == 0) ? 24'($urandom) :
							24'(rate_m / $urandom_range(1, 6));
					endcase
					case ($urandom_range(0, 2))
						0: time_ms = 24'($urandom_range(0, 3));
						1: time_ms = 24'($urandom_range(0, 200));
						default: time_ms = 24'($urandom);
					endcase
					burst = $urandom_range(0, 40);
					queue_item(cmd, goal, speed, time_ms, 8'($urandom));
					queue_ticks(burst);
					done += 1 + burst;
				end
			endcase
		end
	endtask

	initial begin
		logic [stpmc_pkg::CMD_W-1:0] unused_cmd;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset tick_rate
		queue_ticks(1);
		queue_item(stpmc_pkg::CMD_JOG, 32'd0, 24'd0, 24'd0, 8'd0);       // goal equals position
		queue_item(stpmc_pkg::CMD_JOG, 32'd5, 24'd0, 24'd0, 8'd0);       // zero jog speed
		queue_item(stpmc_pkg::CMD_JOG, 32'd3, 24'hFF_FFFF, 24'd0, 8'd0); // faster than the tick
		queue_ticks(3);
		queue_item(stpmc_pkg::CMD_JOG, -32'sd2, 24'd9000000, 24'd0, 8'd0);
		queue_ticks(2);
		queue_item(stpmc_pkg::CMD_ARRIVE, 32'd10, 24'd0, 24'd0, 8'd0);   // zero time
		// goal equals the position, so nothing moves
		queue_item(stpmc_pkg::CMD_ARRIVE, 32'd1, 24'd0, 24'hFF_FFFF, 8'd0);
		queue_item(stpmc_pkg::CMD_ARRIVE, 32'd0, 24'd0, 24'd1, 8'd0);
		queue_item(stpmc_pkg::CMD_FRAME, 32'd2, 24'd0, 24'd0, 8'd0);     // zero frame rate
		queue_item(stpmc_pkg::CMD_FRAME, 32'd2, 24'd0, 24'd0, 8'hFF);
		queue_item(stpmc_pkg::CMD_ZERO, 32'd0, 24'd0, 24'd0, 8'd0);
		// distance 2^31, slow
		queue_item(stpmc_pkg::CMD_JOG, 32'h8000_0000, 24'd1, 24'd0, 8'd0);
		queue_ticks(1);
		queue_item(stpmc_pkg::CMD_JOG, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'hFF);
		queue_ticks(1);
		for (unused_cmd = stpmc_pkg::CMD_ZERO + 3'd1; unused_cmd != 0; unused_cmd++)
			queue_item(unused_cmd, $urandom, 24'($urandom), 24'($urandom), 8'($urandom));
		queue_item(stpmc_pkg::CMD_ZERO, 32'd0, 24'd0, 24'd0, 8'd0);
		// wrap below zero
		queue_item(stpmc_pkg::CMD_JOG, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'd0, 8'd0);
		queue_ticks(1);
		queue_item(stpmc_pkg::CMD_JOG, 32'd1, 24'hFF_FFFF, 24'd0, 8'd0);
		queue_ticks(2);

		queue_random_moves(150);
		set_tick_rate(24'd1);
		queue_random_moves(90);
		set_tick_rate(24'hFF_FFFF);
		queue_random_moves(90);
		set_tick_rate(24'd0);
		queue_random_moves(90);
		set_tick_rate(24'($urandom_range(1, 100000)));
		queue_random_moves(90);
		set_tick_rate(24'($urandom));
		queue_random_moves(90);
		set_tick_rate(stpmc_pkg::TICK_RATE_RESET);
		queue_random_moves(90);

		wait_idle();
		repeat (120) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
